FILE: src/mono_framebuffer_plot_engine_top_assert.svh
// ----------------------------------------------------------------------------
// mono framebuffer plot engine assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_PLOT_ENGINE_TOP_ASSERT_SVH
`define MONO_FRAMEBUFFER_PLOT_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define MFPE_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define MFPE_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define MFPE_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define MFPE_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

FILE: src/mfpe_pkg.sv
// ----------------------------------------------------------------------------
// mfpe_pkg
// types, command codes and helpers of the mono framebuffer plot engine
// ----------------------------------------------------------------------------
package mfpe_pkg;

  localparam int COLUMNS_DEF  = 128;
  localparam int ROWS_DEF     = 32;
  localparam int VLINE_MAX    = 32;
  localparam int HLINE_MAX    = 127;
  localparam int CHUNK_BYTES  = 16;
  localparam int STREAM_BYTES = 1024;
  localparam int STREAM_W     = $clog2(STREAM_BYTES);
  localparam int CHUNK_W      = $clog2(STREAM_BYTES / CHUNK_BYTES);

  localparam logic [2:0] CMD_PIXEL   = 3'd0;
  localparam logic [2:0] CMD_COLUMN  = 3'd1;
  localparam logic [2:0] CMD_VLINE   = 3'd2;
  localparam logic [2:0] CMD_HLINE   = 3'd3;
  localparam logic [2:0] CMD_RECT    = 3'd4;
  localparam logic [2:0] CMD_READOUT = 3'd5;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         x;
    logic [7:0]         y;
    logic [7:0]         x_end;
    logic [7:0]         y_end;
    logic [7:0]         length;
    logic [7:0]         pixel_status;
    logic [7:0]         column_byte;
    logic [CHUNK_W-1:0] chunk;
  } in_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic [STREAM_W-1:0] out_index;
    logic                last_of_chunk;
  } out_t;

  function automatic logic [6:0] vclip(input logic [7:0] n);
    return (n > 8'(VLINE_MAX)) ? 7'(VLINE_MAX) : n[6:0];
  endfunction

  function automatic logic [6:0] hclip(input logic [7:0] n);
    return (n > 8'(HLINE_MAX)) ? 7'(HLINE_MAX) : n[6:0];
  endfunction

  // rows interleave in pairs of half-pages
  function automatic logic [7:0] pixel_mask(input logic [7:0] y);
    return 8'b1 << {y[1:0], y[2]};
  endfunction

endpackage

FILE: src/mfpe_ram.sv
// ----------------------------------------------------------------------------
// mfpe_ram
// generic single-clock ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module mfpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/mono_framebuffer_plot_engine_top.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_plot_engine_top
// plot pixels, byte columns, lines and rectangle outlines into a page store
// every pixel is a read-modify-write of the store, a read state then a write state,
// with a setup state per segment and the idle state to accept; unused cmds are ignored
// readout: a group search by repeated subtraction, then a read and a wait per word
// reset clears the store one entry per cycle, all PAGES*COLUMNS (512) entries, not ready
// ----------------------------------------------------------------------------
`include "mono_framebuffer_plot_engine_top_assert.svh"

module mono_framebuffer_plot_engine_top #(
  parameter int COLUMNS = mfpe_pkg::COLUMNS_DEF,
  parameter int ROWS    = mfpe_pkg::ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mfpe_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mfpe_pkg::out_t out_data
);

  localparam int PAGES  = (ROWS + 7) / 8;
  localparam int DEPTH  = PAGES * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int GRP_W  = $clog2(mfpe_pkg::STREAM_BYTES / COLUMNS + 1);
  localparam int SW     = mfpe_pkg::STREAM_W;
  localparam int IDX_W  = $clog2(mfpe_pkg::CHUNK_BYTES);

  localparam logic [2:0] ST_CLR     = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_SEG     = 3'd2;
  localparam logic [2:0] ST_PIX_RD  = 3'd3;
  localparam logic [2:0] ST_PIX_WR  = 3'd4;
  localparam logic [2:0] ST_RO_DIV  = 3'd5;
  localparam logic [2:0] ST_RO_RD   = 3'd6;
  localparam logic [2:0] ST_RO_WAIT = 3'd7;

  logic [2:0]        state;
  mfpe_pkg::in_t     cur;
  logic [ADDR_W-1:0] clr_addr;
  logic [1:0]        seg;
  logic [7:0]        px;
  logic [7:0]        py;
  logic [6:0]        cnt;
  logic [6:0]        k;
  logic              vert;
  logic [ADDR_W-1:0] pix_addr;
  logic [7:0]        pix_mask;
  logic              pix_we;
  logic              pix_set;
  logic [SW-1:0]     ro_col;
  logic [GRP_W-1:0]  ro_grp;
  logic [SW-1:0]     ro_pos;
  logic [IDX_W-1:0]  ro_i;
  logic              ro_zero;
  logic              ro_odd;

  logic [7:0]        seg_x;
  logic [7:0]        seg_y;
  logic [6:0]        seg_cnt;
  logic              seg_vert;
  logic [7:0]        rect_h;
  logic [7:0]        rect_w;
  logic [1:0]        last_seg;
  logic              in_frame;
  logic [ADDR_W-1:0] pix_addr_c;
  logic              op_set;
  logic              op_clr;
  logic [SW-1:0]     src;
  logic              out_load;
  logic [SW-1:0]     ro_col_inc;

  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [7:0]        ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [7:0]        ram_rd_data;

  assign rect_h   = cur.y_end - cur.y;
  assign rect_w   = cur.x_end - cur.x + 8'd1;
  assign last_seg = (cur.cmd == mfpe_pkg::CMD_RECT) ? 2'd3 : 2'd0;

  always_comb begin
    seg_x    = cur.x;
    seg_y    = cur.y;
    seg_cnt  = 7'd0;
    seg_vert = 1'b1;
    case (cur.cmd)
      mfpe_pkg::CMD_PIXEL:  seg_cnt = 7'd1;
      mfpe_pkg::CMD_COLUMN: seg_cnt = 7'd8;
      mfpe_pkg::CMD_VLINE:  seg_cnt = mfpe_pkg::vclip(cur.length);
      mfpe_pkg::CMD_HLINE: begin
        seg_cnt  = mfpe_pkg::hclip(cur.length);
        seg_vert = 1'b0;
      end
      mfpe_pkg::CMD_RECT: begin
        case (seg)
          2'd0: seg_cnt = mfpe_pkg::vclip(rect_h);
          2'd1: begin
            seg_x   = cur.x_end;
            seg_cnt = mfpe_pkg::vclip(rect_h);
          end
          2'd2: begin
            seg_cnt  = mfpe_pkg::hclip(rect_w);
            seg_vert = 1'b0;
          end
          default: begin
            seg_y    = cur.y_end;
            seg_cnt  = mfpe_pkg::hclip(rect_w);
            seg_vert = 1'b0;
          end
        endcase
      end
      default: ;
    endcase
  end

  // pixel address and operation
  always_comb begin
    in_frame   = ({1'b0, px} < 9'(COLUMNS)) && ({1'b0, py} < 9'(ROWS));
    pix_addr_c = ADDR_W'(32'(py[7:3]) * COLUMNS + 32'(px));
    op_set     = 1'b1;
    op_clr     = 1'b0;
    case (cur.cmd)
      mfpe_pkg::CMD_PIXEL: begin
        op_clr = (cur.pixel_status == 8'd0);
        op_set = $onehot(cur.pixel_status);
      end
      mfpe_pkg::CMD_COLUMN: begin
        op_set = cur.column_byte[k[2:0]];
        op_clr = !cur.column_byte[k[2:0]];
      end
      default: ;
    endcase
  end

  // odd groups show the page of the group below
  assign src        = SW'(32'(ro_grp >> 1) * COLUMNS + 32'(ro_col));
  assign out_load   = (state == ST_RO_WAIT) && (!out_valid || out_ready);
  assign ro_col_inc = ro_col + SW'(1);
  assign in_ready   = (state == ST_IDLE);

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = pix_addr;
    ram_wr_data = pix_set ? (ram_rd_data | pix_mask) : (ram_rd_data & ~pix_mask);
    if (state == ST_CLR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_addr;
      ram_wr_data = 8'd0;
    end else if (state == ST_PIX_WR) begin
      ram_wr_en = pix_we;
    end
    ram_rd_en   = (state == ST_PIX_RD) || (state == ST_RO_RD);
    ram_rd_addr = (state == ST_RO_RD) ? ADDR_W'(src) : pix_addr_c;
  end

  mfpe_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            cur    <= in_data;
            seg    <= 2'd0;
            ro_col <= SW'(in_data.chunk) << IDX_W;
            ro_pos <= SW'(in_data.chunk) << IDX_W;
            ro_grp <= '0;
            ro_i   <= '0;
            if (in_data.cmd == mfpe_pkg::CMD_READOUT) begin
              state <= ST_RO_DIV;
            end else if (in_data.cmd < mfpe_pkg::CMD_READOUT) begin
              state <= ST_SEG;
            end
          end
        end
        ST_SEG: begin
          px   <= seg_x;
          py   <= seg_y;
          cnt  <= seg_cnt;
          vert <= seg_vert;
          k    <= 7'd0;
          if (seg_cnt != 7'd0) begin
            state <= ST_PIX_RD;
          end else if (seg == last_seg) begin
            state <= ST_IDLE;
          end else begin
            seg <= seg + 2'd1;
          end
        end
        ST_PIX_RD: begin
          pix_addr <= pix_addr_c;
          pix_mask <= mfpe_pkg::pixel_mask(py);
          pix_we   <= in_frame && (op_set || op_clr);
          pix_set  <= op_set;
          state    <= ST_PIX_WR;
        end
        ST_PIX_WR: begin
          k <= k + 7'd1;
          if (vert) begin
            py <= py + 8'd1;
          end else begin
            px <= px + 8'd1;
          end
          if (k + 7'd1 != cnt) begin
            state <= ST_PIX_RD;
          end else if (seg == last_seg) begin
            state <= ST_IDLE;
          end else begin
            seg   <= seg + 2'd1;
            state <= ST_SEG;
          end
        end
        ST_RO_DIV: begin
          if (32'(ro_col) >= COLUMNS) begin
            ro_col <= ro_col - SW'(COLUMNS);
            ro_grp <= ro_grp + GRP_W'(1);
          end else begin
            state <= ST_RO_RD;
          end
        end
        ST_RO_RD: begin
          ro_zero <= !(32'(src) < DEPTH);
          ro_odd  <= ro_grp[0];
          state   <= ST_RO_WAIT;
        end
        ST_RO_WAIT: begin
          if (out_load) begin
            out_data.out_byte      <= ro_zero ? 8'd0 :
                                      (ro_odd ? (ram_rd_data >> 1) : ram_rd_data);
            out_data.out_index     <= ro_pos;
            out_data.last_of_chunk <= (ro_i == IDX_W'(mfpe_pkg::CHUNK_BYTES - 1));
            ro_pos <= ro_pos + SW'(1);
            ro_i   <= ro_i + IDX_W'(1);
            if (32'(ro_col_inc) == COLUMNS) begin
              ro_col <= '0;
              ro_grp <= ro_grp + GRP_W'(1);
            end else begin
              ro_col <= ro_col_inc;
            end
            if (ro_i == IDX_W'(mfpe_pkg::CHUNK_BYTES - 1)) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_RO_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MFPE_ASSERT_ALWAYS(a_rst_clears, clk, rst |=> (state == ST_CLR),
                      "reset must start clear pass")
  `MFPE_ASSERT(a_ro_no_write, clk, rst,
               (state == ST_RO_DIV || state == ST_RO_RD || state == ST_RO_WAIT)
               |-> !ram_wr_en, "store written during readout")
  `MFPE_ASSERT(a_rmw_order, clk, rst,
               (ram_wr_en && state == ST_PIX_WR) |-> ($past(state) == ST_PIX_RD),
               "pixel write without read")
  `MFPE_ASSERT(a_wr_range, clk, rst, ram_wr_en |-> (32'(ram_wr_addr) < DEPTH),
               "store write out of range")
  `MFPE_ASSERT(a_chunk_end, clk, rst,
               (out_load && ro_i == IDX_W'(mfpe_pkg::CHUNK_BYTES - 1))
               |=> (state == ST_IDLE && out_valid && out_data.last_of_chunk),
               "chunk end not flagged")

endmodule
